// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/aes_ctr_pkg.sv =====
`default_nettype none
package aes_ctr_pkg;

  localparam int unsigned RegWidth   = 64;
  localparam int unsigned BlockBytes = 16;
  localparam int unsigned BlockBits  = 128;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned Rounds     = 10;

  localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
  localparam logic [1:0] CFG_NONCE    = 2'd2;

  typedef struct packed {
    logic load;   // start a new block: load counter block, add round key 0
    logic round;  // apply one full round
  } dp_cmd_t;

  typedef struct packed {
    logic last_round;  // round counter sits at the final round
  } dp_status_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/aes_ctr_datapath.sv =====
`default_nettype none
module aes_ctr_datapath (
  input  wire logic                   clk,
  input  wire aes_ctr_pkg::dp_cmd_t   cmd,
  input  wire logic [127:0]           key,
  input  wire logic [127:0]           ctr_block,
  output aes_ctr_pkg::dp_status_t     status,
  output logic [127:0]                state_out
);
  // State byte i sits at bits [127-8i -: 8]; round key computed on the fly.
  logic [127:0] state;
  logic [127:0] rkey;
  logic [3:0]   rnd;
  logic [127:0] state_next;
  logic [127:0] rkey_next;
  logic [127:0] sr;
  logic [127:0] mc;
  logic [31:0]  tw;

  always_comb begin
    tw = {aes_ctr_pkg::sbox(rkey[23:16]), aes_ctr_pkg::sbox(rkey[15:8]),
          aes_ctr_pkg::sbox(rkey[7:0]), aes_ctr_pkg::sbox(rkey[31:24])}
         ^ {aes_ctr_pkg::rcon(rnd + 4'd1), 24'h0};
    rkey_next[127:96] = rkey[127:96] ^ tw;
    rkey_next[95:64]  = rkey[95:64] ^ rkey_next[127:96];
    rkey_next[63:32]  = rkey[63:32] ^ rkey_next[95:64];
    rkey_next[31:0]   = rkey[31:0] ^ rkey_next[63:32];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127-8*(4*c+r) -: 8] = aes_ctr_pkg::sbox(state[127-8*(4*((c+r)%4)+r) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = sr[127-32*c -: 8];
      a1 = sr[119-32*c -: 8];
      a2 = sr[111-32*c -: 8];
      a3 = sr[103-32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[127-32*c -: 8] = a0 ^ al ^ aes_ctr_pkg::xtime(a0 ^ a1);
      mc[119-32*c -: 8] = a1 ^ al ^ aes_ctr_pkg::xtime(a1 ^ a2);
      mc[111-32*c -: 8] = a2 ^ al ^ aes_ctr_pkg::xtime(a2 ^ a3);
      mc[103-32*c -: 8] = a3 ^ al ^ aes_ctr_pkg::xtime(a3 ^ a0);
    end
    state_next = ((rnd == 4'(aes_ctr_pkg::Rounds - 1)) ? sr : mc) ^ rkey_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      state <= ctr_block ^ key;
      rkey  <= key;
      rnd   <= '0;
    end else if (cmd.round) begin
      state <= state_next;
      rkey  <= rkey_next;
      rnd   <= rnd + 4'd1;
    end
  end

  assign status.last_round = (rnd == 4'(aes_ctr_pkg::Rounds - 1));
  // Result of the round in progress; the ciphertext on the final round.
  assign state_out = state_next;
endmodule
`default_nettype wire

// ===== sv/aes_ctr_ctrl.sv =====
`default_nettype none
module aes_ctr_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire aes_ctr_pkg::dp_status_t status,
  output aes_ctr_pkg::dp_cmd_t        cmd,
  output logic                        done
);
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_ROUND = 2'b10
  } state_t;

  state_t st, st_next;

  always_comb begin
    st_next  = st;
    cmd      = '0;
    done     = 1'b0;
    case (st)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          st_next  = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (status.last_round) begin
          done    = 1'b1;
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end
endmodule
`default_nettype wire

// ===== sv/aes128_ctr_stream.sv =====
// AES-128 counter-mode byte stream; encrypt and decrypt are the same.
// Input channel: data_byte/message_end with in_valid/in_ready. Output
// channel: result_byte/result_last with out_valid/out_ready; one word out
// per word in. Config: cfg_we, cfg_index (0 key_high, 1 key_low, 2 nonce),
// cfg_data; write only while idle, other indexes are ignored.
// At the first byte of each 16-byte block the counter block (nonce LE in
// bytes 0..7, block counter LE in bytes 8..15) is encrypted by one
// iterative AES core, one round per cycle, and that word is output when
// the core is done. Other words are output from the stored keystream.
// in_ready stays low while a block is being encrypted.
// The round keys are derived on the fly alongside the rounds.
// message_end resets the block counter and byte position after that word.
// When the receiver stalls, the result holds in the output register and
// in_ready drops until it is taken. Reset (rst, synchronous) clears the
// counter, position, output valid, key and nonce registers.
`default_nettype none
`include "assert_macros.svh"
module aes128_ctr_stream (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [aes_ctr_pkg::RegWidth-1:0]   cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [7:0]                         data_byte,
  input  wire logic                               message_end,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [7:0]                              result_byte,
  output logic                                    result_last
);
  logic [aes_ctr_pkg::RegWidth-1:0] key_high, key_low, nonce_value, block_counter;
  logic [3:0]   byte_position;
  logic [127:0] keystream;
  logic         busy;
  logic [7:0]   pend_byte;
  logic         pend_last;
  logic [127:0] ctr_block;
  logic [127:0] core_out;
  logic         start, done;
  logic         accept, fire;
  aes_ctr_pkg::dp_cmd_t    cmd;
  aes_ctr_pkg::dp_status_t status;

  // Counter block: nonce then counter, each least significant byte first.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ctr_block[127-8*i -: 8]     = nonce_value[8*i +: 8];
      ctr_block[127-8*(8+i) -: 8] = block_counter[8*i +: 8];
    end
  end

  assign in_ready = !busy && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign start    = accept && (byte_position == 4'd0);
  // Emit the word directly unless a fresh block is needed.
  assign fire     = accept && (byte_position != 4'd0);

  aes_ctr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .status(status), .cmd(cmd), .done(done)
  );

  aes_ctr_datapath u_dp (
    .clk(clk), .cmd(cmd), .key({key_high, key_low}), .ctr_block(ctr_block),
    .status(status), .state_out(core_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high      <= '0;
      key_low       <= '0;
      nonce_value   <= '0;
      block_counter <= '0;
      byte_position <= '0;
      busy          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          aes_ctr_pkg::CFG_KEY_HIGH: key_high    <= cfg_data;
          aes_ctr_pkg::CFG_KEY_LOW:  key_low     <= cfg_data;
          aes_ctr_pkg::CFG_NONCE:    nonce_value <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        byte_position <= message_end ? 4'd0 : byte_position + 4'd1;
        if (message_end) begin
          block_counter <= '0;
        end else if (byte_position == 4'd0) begin
          block_counter <= block_counter + 1'b1;
        end
      end
      // Raise valid on a new word, drop it once the receiver takes it.
      if (fire || done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (start) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  // Payload registers: hold the pending word and the keystream block.
  always_ff @(posedge clk) begin
    if (start) begin
      pend_byte <= data_byte;
      pend_last <= message_end;
    end
    if (fire) begin
      result_byte <= data_byte ^ keystream[127-8*byte_position -: 8];
      result_last <= message_end;
    end else if (done) begin
      // Round key 10 lands in the core the same edge; core_out is the block.
      keystream   <= core_out;
      result_byte <= pend_byte ^ core_out[127:120];
      result_last <= pend_last;
    end
  end

  `ASSERT_CLK(a_ready_idle, clk, rst, busy |-> !in_ready, "input taken during block encryption")
  `ASSERT_CLK(a_done_busy, clk, rst, done |-> busy, "core finished with no block pending")
  `ASSERT_CLK(a_start_pos, clk, rst, start |-> (byte_position == 4'd0), "block started mid-block")
endmodule
`default_nettype wire
